FILE: src/lirs_pkg.sv
package lirs_pkg;

  // what the front end found out about a word
  typedef enum logic {
    KIND_FIRST  = 1'b0,
    KIND_INTERP = 1'b1
  } lirs_kind_e;

  // an input produces at most this many outputs
  localparam int MAX_OUT = 3;
  localparam int CNT_W = 2;
  localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(MAX_OUT - 1);

endpackage

FILE: src/lirs_if.sv
interface lirs_in_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface lirs_out_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] out_sample;
  logic                          last;

  modport source (output valid, output out_sample, output last, input ready);
  modport sink (input valid, input out_sample, input last, output ready);
endinterface

FILE: src/lirs_front.sv
module lirs_front #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  lirs_in_if.sink                       smp_i,
  input  logic                          full_i,
  output logic                          push_o,
  output lirs_pkg::lirs_kind_e          kind_o,
  output logic signed [SAMPLE_BITS-1:0] prev_o,
  output logic signed [SAMPLE_BITS-1:0] cur_o
);
  import lirs_pkg::*;

  logic                          have_prev_q;
  logic signed [SAMPLE_BITS-1:0] prev_q;

  assign smp_i.ready = !full_i;
  assign push_o      = smp_i.valid && !full_i;
  assign kind_o      = have_prev_q ? KIND_INTERP : KIND_FIRST;
  assign prev_o      = prev_q;
  assign cur_o       = smp_i.sample;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_prev_q <= 1'b0;
      prev_q      <= '0;
    end else if (push_o) begin
      have_prev_q <= 1'b1;
      prev_q      <= smp_i.sample;
    end
  end

endmodule

FILE: src/lirs_fifo.sv
module lirs_fifo #(
  parameter int WIDTH = 33
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             valid_o,
  output logic             full_o
);
  import lirs_pkg::*;

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_q;
  logic             rd_q;
  logic [1:0]       cnt_q;
  logic [1:0]       cnt_d;

  assign data_o  = mem_q[rd_q];
  assign valid_o = (cnt_q != 2'd0);
  assign full_o  = (cnt_q == 2'd2);

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= !wr_q;
      end
      if (pop_i) begin
        rd_q <= !rd_q;
      end
      cnt_q <= cnt_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("pop from empty queue");

  a_count_matches_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd1) == (wr_q != rd_q))
    else $error("queue count and pointers disagree");

endmodule

FILE: src/lirs_back.sv
module lirs_back #(
  parameter int SAMPLE_BITS = 16,
  parameter int FRAC_BITS   = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [FRAC_BITS+1:0]          cfg_data_i,
  input  logic                          head_valid_i,
  input  lirs_pkg::lirs_kind_e          head_kind_i,
  input  logic signed [SAMPLE_BITS-1:0] head_prev_i,
  input  logic signed [SAMPLE_BITS-1:0] head_cur_i,
  output logic                          pop_o,
  lirs_out_if.source                    res_o
);
  import lirs_pkg::*;

  localparam int PH_W  = FRAC_BITS + 2;
  localparam int SB    = SAMPLE_BITS;
  localparam int PRD_W = SB + PH_W + 2;
  localparam logic [PH_W-1:0] ONE      = PH_W'(1) << FRAC_BITS;
  localparam logic [PH_W-1:0] STEP_MIN = ONE >> 1;
  localparam logic [PH_W-1:0] STEP_MAX = ONE << 1;

  logic [PH_W-1:0]         step_q;
  logic [PH_W-1:0]         phase_q, phase_d;
  logic [CNT_W-1:0]        n_q, n_d;
  logic                    ov_q, ov_d;
  logic signed [SB-1:0]    os_q, os_d;
  logic                    ol_q, ol_d;

  logic                    adv;
  logic signed [SB:0]      diff;
  logic signed [PRD_W-1:0] prod;
  logic signed [PRD_W-1:0] interp;
  logic [PH_W:0]           nxt;
  logic [PH_W-1:0]         wrap;
  logic                    in_range;
  logic                    is_last;
  logic [PH_W-1:0]         step_clamp;

  always_comb begin
    if (cfg_data_i < STEP_MIN) begin
      step_clamp = STEP_MIN;
    end else if (cfg_data_i > STEP_MAX) begin
      step_clamp = STEP_MAX;
    end else begin
      step_clamp = cfg_data_i;
    end
  end

  // one interpolation a cycle through the shared multiplier while the output is not stalled
  assign diff   = {head_cur_i[SB-1], head_cur_i} - {head_prev_i[SB-1], head_prev_i};
  assign prod   = $signed({{(PRD_W-SB-1){diff[SB]}}, diff})
                * $signed({{(PRD_W-PH_W){1'b0}}, phase_q});
  assign interp = (prod >>> FRAC_BITS) + $signed({{(PRD_W-SB){head_prev_i[SB-1]}}, head_prev_i});

  assign nxt      = {1'b0, phase_q} + {1'b0, step_q};
  assign in_range = (phase_q <= ONE);
  assign is_last  = (nxt > {1'b0, ONE}) || (n_q == LAST_IDX);
  assign wrap     = (nxt >= {1'b0, ONE}) ? PH_W'(nxt - {1'b0, ONE}) : '0;

  assign adv = head_valid_i && (!ov_q || res_o.ready);

  always_comb begin
    phase_d = phase_q;
    n_d     = n_q;
    ov_d    = ov_q && !res_o.ready;
    os_d    = os_q;
    ol_d    = ol_q;
    pop_o   = 1'b0;
    if (adv) begin
      if (head_kind_i == KIND_FIRST) begin
        ov_d    = 1'b1;
        os_d    = head_cur_i;
        ol_d    = 1'b1;
        phase_d = '0;
        n_d     = '0;
        pop_o   = 1'b1;
      end else if (!in_range) begin
        // phase already past one: no output, just wrap
        phase_d = phase_q - ONE;
        n_d     = '0;
        pop_o   = 1'b1;
      end else begin
        ov_d = 1'b1;
        os_d = interp[SB-1:0];
        ol_d = is_last;
        if (is_last) begin
          phase_d = wrap;
          n_d     = '0;
          pop_o   = 1'b1;
        end else begin
          phase_d = nxt[PH_W-1:0];
          n_d     = n_q + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= ONE;
      phase_q <= '0;
      n_q     <= '0;
      ov_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        step_q <= step_clamp;
      end
      phase_q <= phase_d;
      n_q     <= n_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    os_q <= os_d;
    ol_q <= ol_d;
  end

  assign res_o.valid      = ov_q;
  assign res_o.out_sample = os_q;
  assign res_o.last       = ol_q;

  a_step_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q >= STEP_MIN && step_q <= STEP_MAX)
    else $error("phase step outside clamp range");

  a_phase_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q <= STEP_MAX)
    else $error("phase above two");

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= LAST_IDX)
    else $error("output count past limit");

  a_third_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && head_kind_i == KIND_INTERP && in_range && n_q == LAST_IDX)
      |=> (res_o.valid && res_o.last))
    else $error("third output not marked last");

endmodule

FILE: src/linear_interp_resampler_top.sv
// Linear interpolation resampler. Each input word is one signed sample; each
// output word is an interpolated sample plus a last flag on the final output
// for that input. The first sample after reset comes out unchanged; every
// later sample yields 0 to 3 outputs at phases up to and including 1.0,
// stepped by phase_step (Q2.FRAC_BITS, clamped to 0.5..2.0 on write, reset
// value 1.0). Inputs go into a two-word queue and are taken at one per cycle
// while it has room. The back end has one multiplier and gives one output per
// cycle while the output is not stalled; an input that gives no output is
// popped without one. Sustained throughput is set by the outputs per input.
// Write phase_step only while the block is idle.
module linear_interp_resampler_top #(
  parameter int SAMPLE_BITS = 16,
  parameter int FRAC_BITS   = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [FRAC_BITS+1:0] cfg_data_i,
  lirs_in_if.sink              smp_i,
  lirs_out_if.source           res_o
);
  import lirs_pkg::*;

  localparam int QW = 2 * SAMPLE_BITS + 1;

  logic                          push;
  logic                          full;
  logic                          pop;
  logic                          head_valid;
  lirs_kind_e                    push_kind;
  logic signed [SAMPLE_BITS-1:0] push_prev;
  logic signed [SAMPLE_BITS-1:0] push_cur;
  logic [QW-1:0]                 head;

  lirs_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .smp_i  (smp_i),
    .full_i (full),
    .push_o (push),
    .kind_o (push_kind),
    .prev_o (push_prev),
    .cur_o  (push_cur)
  );

  lirs_fifo #(
    .WIDTH (QW)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  ({push_kind, push_prev, push_cur}),
    .pop_i   (pop),
    .data_o  (head),
    .valid_o (head_valid),
    .full_o  (full)
  );

  lirs_back #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_data_i),
    .head_valid_i (head_valid),
    .head_kind_i  (lirs_kind_e'(head[QW-1])),
    .head_prev_i  ($signed(head[2*SAMPLE_BITS-1:SAMPLE_BITS])),
    .head_cur_i   ($signed(head[SAMPLE_BITS-1:0])),
    .pop_o        (pop),
    .res_o        (res_o)
  );

endmodule
